[hdl/dct_8x8_forward_defines.svh]
// Assertion macros used by the port-level checker file.
`ifndef DCT_8X8_FORWARD_DEFINES_SVH
`define DCT_8X8_FORWARD_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DCT8_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dct8 check failed");

// Next-cycle implication, disabled while reset is low.
`define DCT8_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dct8 check failed");

`endif

[hdl/dct8_pkg.sv]
// Types, constants and basis table of the 8x8 forward DCT.
`default_nettype none
package dct8_pkg;

  localparam int N          = 8;
  localparam int AREA       = N * N;
  localparam int SAMP_W     = 8;
  localparam int BASIS_W    = 22;
  localparam int ACC_W      = 56;
  localparam int COEF_W     = 12;
  localparam int FRAC_SHIFT = 42;
  localparam int Q_W        = ACC_W - FRAC_SHIFT;

  typedef logic signed [BASIS_W-1:0] basis_t;

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_FETCH = 5'b00010,
    S_SER   = 5'b00100,
    S_OUT   = 5'b01000,
    S_SPARE = 5'b10000
  } state_t;

  // cos(r*pi/16) in Q20 for r in 0..8
  function automatic basis_t cos_quad(input logic [3:0] r);
    basis_t c;
    unique case (r)
      4'd0:    c = 22'sd1048576;
      4'd1:    c = 22'sd1028428;
      4'd2:    c = 22'sd968758;
      4'd3:    c = 22'sd871859;
      4'd4:    c = 22'sd741455;
      4'd5:    c = 22'sd582558;
      4'd6:    c = 22'sd401273;
      4'd7:    c = 22'sd204567;
      default: c = 22'sd0;
    endcase
    return c;
  endfunction

  // cos(k*pi/16) in Q20 for k mod 32, folded by quadrant
  function automatic basis_t cos_idx(input logic [4:0] k);
    basis_t c;
    if (k <= 5'd8) begin
      c = cos_quad(k[3:0]);
    end else if (k <= 5'd16) begin
      c = -cos_quad(4'(5'd16 - k));
    end else if (k <= 5'd24) begin
      c = -cos_quad(4'(k - 5'd16));
    end else begin
      c = cos_quad(4'(6'd32 - {1'b0, k}));
    end
    return c;
  endfunction

  // b(u,x) in Q20, with the DC row scaled by 1/sqrt2
  function automatic basis_t basis(input logic [2:0] u, input logic [2:0] x);
    logic [4:0] k;
    // wrap the angle index mod 32
    k = {1'b0, x, 1'b1} * {2'b00, u};
    if (u == 3'd0) begin
      return 22'sd741455;
    end
    return cos_idx(k);
  endfunction

endpackage
`default_nettype wire

[hdl/dct_8x8_forward.sv]
// Top level of the 8x8 forward DCT with a bit-serial multiply-accumulate.
//
// Usage: drive in_sample with start high while busy is low; each such
// transfer stores one sample of the block in raster order. On the 64th
// sample busy rises and the block computes the 64 coefficients in raster
// order (u, then v). Each coefficient appears on out_coefficient for one
// cycle with out_valid high; out_last marks the 64th. The receiver cannot
// stall the block, so results are lost if not captured.
// Schedule: one coefficient sums 64 products; each product passes a fetch
// state (store read and basis multiply) and then a serial state that shifts
// the sample one bit a cycle into the accumulator; an output state then
// registers the coefficient. The bit-serial accumulator sets the compute
// time. busy falls with the last coefficient and the next block may load
// at once.
// Reset: rst_n low clears the load count and the state; the sample store
// holds no reset value and is always written before it is read.
`default_nettype none
module dct_8x8_forward
  import dct8_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [SAMP_W-1:0]        in_sample,
  output logic                          out_valid,
  output logic signed [COEF_W-1:0]      out_coefficient,
  output logic                          out_last
);

  logic [SAMP_W-1:0] store_mem [AREA];

  state_t            state_r, state_nxt;
  logic [5:0]        load_r, load_nxt;
  logic [5:0]        coef_r, coef_nxt;
  logic [5:0]        term_r, term_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [SAMP_W-1:0] samp_r;
  logic signed [ACC_W-1:0] prod_r, acc_r;
  logic              valid_r, last_r;
  logic signed [COEF_W-1:0] coef_out_r;

  logic              accept;
  logic signed [2*BASIS_W-1:0] prod_full;
  logic [ACC_W-1:0]  mag;
  logic [Q_W-1:0]    q;
  logic signed [COEF_W-1:0] coef_val;

  assign accept    = start && (state_r == S_LOAD);
  assign busy      = (state_r != S_LOAD);
  assign prod_full = basis(coef_r[5:3], term_r[5:3]) * basis(coef_r[2:0], term_r[2:0]);

  // round the magnitude toward zero, then saturate
  assign mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign q   = mag[ACC_W-1:FRAC_SHIFT];
  always_comb begin
    if (acc_r[ACC_W-1]) begin
      coef_val = (q > Q_W'(2048)) ? COEF_W'(12'h800) : COEF_W'(Q_W'(0) - q);
    end else begin
      coef_val = (q > Q_W'(2047)) ? COEF_W'(12'h7FF) : COEF_W'(q);
    end
  end

  always_comb begin
    state_nxt = state_r;
    load_nxt  = load_r;
    coef_nxt  = coef_r;
    term_nxt  = term_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          load_nxt = load_r + 6'd1;
          if (load_r == 6'(AREA - 1)) begin
            state_nxt = S_FETCH;
            coef_nxt  = '0;
            term_nxt  = '0;
          end
        end
      end
      S_FETCH: begin
        bit_nxt   = '0;
        state_nxt = S_SER;
      end
      S_SER: begin
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'(SAMP_W - 1)) begin
          term_nxt  = term_r + 6'd1;
          state_nxt = (term_r == 6'(AREA - 1)) ? S_OUT : S_FETCH;
        end
      end
      S_OUT: begin
        coef_nxt  = coef_r + 6'd1;
        state_nxt = (coef_r == 6'(AREA - 1)) ? S_LOAD : S_FETCH;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      load_r  <= '0;
      coef_r  <= '0;
      term_r  <= '0;
      bit_r   <= '0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      load_r  <= load_nxt;
      coef_r  <= coef_nxt;
      term_r  <= term_nxt;
      bit_r   <= bit_nxt;
      valid_r <= (state_r == S_OUT);
      last_r  <= (state_r == S_OUT) && (coef_r == 6'(AREA - 1));
    end
  end

  // store, sample and product shift registers, accumulator and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      store_mem[load_r] <= in_sample;
    end
    if (state_r == S_FETCH) begin
      samp_r <= store_mem[term_r];
      prod_r <= ACC_W'(prod_full);
    end else if (state_r == S_SER) begin
      samp_r <= samp_r >> 1;
      prod_r <= prod_r <<< 1;
    end
    if ((accept && load_r == 6'(AREA - 1)) || state_r == S_OUT) begin
      acc_r <= '0;
    end else if (state_r == S_SER && samp_r[0]) begin
      acc_r <= acc_r + prod_r;
    end
    if (state_r == S_OUT) begin
      coef_out_r <= coef_val;
    end
  end

  assign out_valid       = valid_r;
  assign out_last        = last_r;
  assign out_coefficient = coef_out_r;

endmodule
`default_nettype wire

[hdl/dct8_chk.sv]
// Port-level checker of the 8x8 forward DCT and its bind.
`default_nettype none
`include "dct_8x8_forward_defines.svh"
module dct8_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_last
);

  `DCT8_ASSERT_IMP(a_last_strobed, clk, rst_n, out_last, out_valid)
  `DCT8_ASSERT_NXT(a_strobe_gap, clk, rst_n, out_valid, !out_valid)
  `DCT8_ASSERT_IMP(a_busy_midblock, clk, rst_n, out_valid && !out_last, busy)
  `DCT8_ASSERT_NXT(a_idle_quiet, clk, rst_n, !busy && !out_valid, !out_valid)

endmodule

bind dct_8x8_forward dct8_chk u_dct8_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_last  (out_last)
);
`default_nettype wire
